FILE: hw/rtl/aps_pkg.sv
// Package for the aim point smoother: widths, constants, exp table, sequencer states.
// Used by aps_divider.sv, aim_point_smoother.sv and the testbench; depends on nothing.
package aps_pkg;

    localparam int SLOTS     = 8;
    localparam int SLOT_W    = $clog2(SLOTS);
    // The shared counter walks the slots and also the 16 exp table steps.
    localparam int CNT_W     = ($clog2(SLOTS) > 4) ? $clog2(SLOTS) : 4;

    localparam logic [30:0] RADIUS_MIN = 31'd3277;
    localparam logic [30:0] RADIUS_MAX = 31'd655359;
    localparam logic [31:0] MIN_ABOVE  = 32'd6554;
    localparam logic [47:0] STALE_US   = 48'd1500000;

    localparam logic [19:0] FALLBACK_RST = 20'd78643;
    localparam logic [11:0] FACTOR_RST   = 12'd384;
    localparam logic [23:0] SMOOTH_RST   = 24'd100000;

    localparam logic [1:0] REG_FALLBACK = 2'd0;
    localparam logic [1:0] REG_FACTOR   = 2'd1;
    localparam logic [1:0] REG_SMOOTH   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_VICTIM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EXP,
        ST_BLEND_MUL,
        ST_BLEND_ADD,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;

    function automatic logic [23:0] exp_factor(input logic [3:0] k);
        logic [23:0] r;
        begin
            case (k)
                4'd0:  r = 24'd16773120;
                4'd1:  r = 24'd16769026;
                4'd2:  r = 24'd16760840;
                4'd3:  r = 24'd16744480;
                4'd4:  r = 24'd16711808;
                4'd5:  r = 24'd16646655;
                4'd6:  r = 24'd16517109;
                4'd7:  r = 24'd16261035;
                4'd8:  r = 24'd15760736;
                4'd9:  r = 24'd14805841;
                4'd10: r = 24'd13066109;
                4'd11: r = 24'd10175896;
                4'd12: r = 24'd6171993;
                4'd13: r = 24'd2270549;
                4'd14: r = 24'd307285;
                default: r = 24'd5628;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        begin
            if (v > 34'sd2147483647)       r = 32'h7FFF_FFFF;
            else if (v < -34'sd2147483648) r = 32'h8000_0000;
            else                           r = v[31:0];
            return r;
        end
    endfunction

endpackage

FILE: hw/rtl/aps_if.sv
// Valid/ready channel interfaces for the aim point smoother.
// Depends on nothing but plain logic types.
interface aps_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] target_id;
    logic [47:0] time_us;
    logic        bound_valid;
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] centre_z;
    logic [30:0] sphere_radius;
    logic signed [31:0] feet_x;
    logic signed [31:0] feet_y;
    logic signed [31:0] feet_z;
    modport source (output valid, target_id, time_us, bound_valid, centre_x, centre_y,
                    centre_z, sphere_radius, feet_x, feet_y, feet_z, input ready);
    modport sink (input valid, target_id, time_us, bound_valid, centre_x, centre_y,
                  centre_z, sphere_radius, feet_x, feet_y, feet_z, output ready);
endinterface

interface aps_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic        used_fallback;
    modport source (output valid, aim_x, aim_y, aim_z, used_fallback, input ready);
    modport sink (input valid, aim_x, aim_y, aim_z, used_fallback, output ready);
endinterface

FILE: hw/rtl/aps_divider.sv
// Restoring divider, one quotient bit per cycle: (dt << 12) / smoothing_time.
// Depends on aps_pkg. Quotient saturates its caller's use at 2^16 by a flag.
module aps_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  aps_pkg::div_ctl_t ctl_in,
    input  logic [32:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [32:0] quotient
);
    logic [32:0] quot_reg, quot_next;
    logic [24:0] rem_reg, rem_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [24:0] trial;

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[23:0], quot_reg[32]};
        if (ctl_in.start)
        begin
            quot_next = dividend;
            rem_next  = '0;
            cnt_next  = 6'd33;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next  = trial - {1'b0, divisor};
                quot_next = {quot_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = trial;
                quot_next = {quot_reg[31:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done     = !busy_reg && !ctl_in.start && !ctl_in.busy;
    assign quotient = quot_reg;
endmodule

FILE: hw/rtl/aim_point_smoother.sv
// Aim point smoother top level: keyed offset smoothing over an 8-slot table.
// Path: a fallback word, or a word with smoothing off, goes straight to the output; a table
// miss takes two slot scans (search, then victim pick), a stale hit a slot scan, and a fresh
// hit a slot scan, a divide, up to 16 exp steps and a blend; every table path then writes.
// Flow: one word at a time; the next word is accepted only after the result loads, which
// waits while an earlier result is held. Reset: control, config and valid registers reset.
module aim_point_smoother (
    input  logic        clk,
    input  logic        rst_n,
    aps_in_if.sink      in_ch,
    aps_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);
    localparam int SW = aps_pkg::SLOT_W;

    aps_pkg::state_t state_reg, state_next;

    logic [19:0] fallback_reg;
    logic [11:0] factor_reg;
    logic [23:0] smooth_reg;

    logic [aps_pkg::SLOTS-1:0] used_reg;
    logic [31:0] key_mem [aps_pkg::SLOTS];
    logic [31:0] offx_mem [aps_pkg::SLOTS];
    logic [31:0] offy_mem [aps_pkg::SLOTS];
    logic [31:0] offz_mem [aps_pkg::SLOTS];
    logic [47:0] time_mem [aps_pkg::SLOTS];

    // latched input word
    logic [31:0] id_reg;
    logic [47:0] now_reg;
    logic signed [31:0] fx_reg, fy_reg, fz_reg;
    logic [31:0] ox_reg, oy_reg, oz_reg;
    logic fb_reg;

    logic [SW-1:0] idx_reg, pick_reg;
    logic [aps_pkg::CNT_W-1:0] cnt_reg;
    logic hit_reg;
    logic [47:0] best_reg;
    logic [47:0] last_reg;

    logic [24:0] e_reg;
    logic [16:0] alpha_reg;
    logic [15:0] q_reg;
    logic [1:0]  comp_reg;
    logic signed [50:0] prod_reg;

    logic        out_valid_reg;
    logic [31:0] aim_x_reg, aim_y_reg, aim_z_reg;
    logic        out_fb_reg;

    aps_pkg::div_ctl_t div_ctl;
    logic        div_done;
    logic [32:0] div_q;

    wire [47:0] dt = now_reg - last_reg;

    aps_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl_in   (div_ctl),
        .dividend ({dt[20:0], 12'd0}),
        .divisor  (smooth_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    wire accept_in = in_ch.valid && in_ch.ready;
    wire [SW-1:0] cnt_idx = cnt_reg[SW-1:0];
    wire cnt_last = (cnt_reg == aps_pkg::CNT_W'(aps_pkg::SLOTS - 1));
    wire stale = (now_reg <= last_reg) || (dt > aps_pkg::STALE_US);

    // raw offset combinational from the input word
    logic signed [32:0] dxw, dyw, dzw;
    logic [31:0] above;
    logic [43:0] hprod;
    logic [35:0] hval;
    logic bad;
    always_comb
    begin
        dxw   = 33'(in_ch.centre_x) - 33'(in_ch.feet_x);
        dyw   = 33'(in_ch.centre_y) - 33'(in_ch.feet_y);
        dzw   = 33'(in_ch.centre_z) - 33'(in_ch.feet_z);
        above = dzw[32] ? 32'd0 : dzw[31:0];
        hprod = 44'(above) * 44'(factor_reg);
        hval  = hprod[43:8];
        if (hval < 36'(aps_pkg::MIN_ABOVE))
            hval = 36'(aps_pkg::MIN_ABOVE);
        bad = !in_ch.bound_valid || in_ch.sphere_radius < aps_pkg::RADIUS_MIN
              || in_ch.sphere_radius > aps_pkg::RADIUS_MAX;
    end

    // multipliers: exp chain step and blend product
    logic [31:0] sel_old, sel_raw;
    logic signed [32:0] diff;
    logic [48:0] emul;
    logic signed [50:0] bmul;
    logic signed [51:0] rnd;
    logic signed [33:0] blended;
    always_comb
    begin
        case (comp_reg)
            2'd0:    begin sel_old = offx_mem[idx_reg]; sel_raw = ox_reg; end
            2'd1:    begin sel_old = offy_mem[idx_reg]; sel_raw = oy_reg; end
            default: begin sel_old = offz_mem[idx_reg]; sel_raw = oz_reg; end
        endcase
        diff = 33'($signed(sel_raw)) - 33'($signed(sel_old));
        emul = e_reg * 49'(aps_pkg::exp_factor(cnt_reg[3:0])) + 49'd8388608;
        bmul = 51'(diff) * $signed({34'd0, alpha_reg});
        rnd  = 52'(prod_reg) + 52'sd32768;
        blended = 34'($signed(sel_old)) + 34'(rnd >>> 16);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aps_pkg::ST_IDLE:
                if (accept_in)
                    state_next = (bad || smooth_reg == '0) ? aps_pkg::ST_OUT
                                                           : aps_pkg::ST_SEARCH;
            aps_pkg::ST_SEARCH:
                if (used_reg[cnt_idx] && key_mem[cnt_idx] == id_reg)
                    state_next = aps_pkg::ST_DIV_START;
                else if (cnt_last)
                    state_next = aps_pkg::ST_VICTIM;
            aps_pkg::ST_VICTIM:
                if (cnt_last)
                    state_next = aps_pkg::ST_WRITE;
            aps_pkg::ST_DIV_START:
                state_next = stale ? aps_pkg::ST_WRITE : aps_pkg::ST_DIV_WAIT;
            aps_pkg::ST_DIV_WAIT:
                if (div_done)
                    state_next = aps_pkg::ST_EXP;
            aps_pkg::ST_EXP:
                if (cnt_reg == aps_pkg::CNT_W'(0) && q_reg == '0 || cnt_reg[3:0] == 4'd15)
                    state_next = aps_pkg::ST_BLEND_MUL;
                else if (alpha_reg[16])
                    state_next = aps_pkg::ST_BLEND_MUL;
            aps_pkg::ST_BLEND_MUL:
                state_next = aps_pkg::ST_BLEND_ADD;
            aps_pkg::ST_BLEND_ADD:
                state_next = (comp_reg == 2'd2) ? aps_pkg::ST_WRITE : aps_pkg::ST_BLEND_MUL;
            aps_pkg::ST_WRITE:
                state_next = aps_pkg::ST_OUT;
            aps_pkg::ST_OUT:
                if (!out_valid_reg || out_ch.ready)
                    state_next = aps_pkg::ST_IDLE;
            default:
                state_next = aps_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ch.ready   = (state_reg == aps_pkg::ST_IDLE);
        div_ctl.start = (state_reg == aps_pkg::ST_DIV_START) && !stale;
        div_ctl.busy  = (state_reg == aps_pkg::ST_DIV_START);
        div_ctl.done  = div_done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aps_pkg::ST_IDLE;
            fallback_reg  <= aps_pkg::FALLBACK_RST;
            factor_reg    <= aps_pkg::FACTOR_RST;
            smooth_reg    <= aps_pkg::SMOOTH_RST;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aps_pkg::REG_FALLBACK: fallback_reg <= cfg_data[19:0];
                    aps_pkg::REG_FACTOR:   factor_reg   <= cfg_data[11:0];
                    aps_pkg::REG_SMOOTH:   smooth_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == aps_pkg::ST_OUT && (!out_valid_reg || out_ch.ready))
                out_valid_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == aps_pkg::ST_WRITE && !hit_reg)
                used_reg[idx_reg] <= 1'b1;
            unique case (state_reg)
                aps_pkg::ST_SEARCH, aps_pkg::ST_VICTIM:
                    cnt_reg <= (cnt_last || state_next != state_reg) ? '0 : cnt_reg + 1'b1;
                aps_pkg::ST_EXP:
                    cnt_reg <= cnt_reg + 1'b1;
                default:
                    cnt_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            aps_pkg::ST_IDLE:
                if (accept_in)
                begin
                    id_reg  <= in_ch.target_id;
                    now_reg <= in_ch.time_us;
                    fx_reg  <= in_ch.feet_x;
                    fy_reg  <= in_ch.feet_y;
                    fz_reg  <= in_ch.feet_z;
                    fb_reg  <= bad;
                    ox_reg  <= aps_pkg::sat32(34'(dxw));
                    oy_reg  <= aps_pkg::sat32(34'(dyw));
                    oz_reg  <= bad ? 32'(fallback_reg)
                                   : aps_pkg::sat32(34'($signed({1'b0, hval[31:0]})) |
                                       (hval[35:32] != '0 ? 34'sh7FFFFFFF : 34'sd0));
                    hit_reg <= 1'b0;
                end
            aps_pkg::ST_SEARCH:
            begin
                if (used_reg[cnt_idx] && key_mem[cnt_idx] == id_reg)
                begin
                    hit_reg  <= 1'b1;
                    idx_reg  <= cnt_idx;
                    last_reg <= time_mem[cnt_idx];
                end
                pick_reg <= '0;
                best_reg <= time_mem[0];
            end
            aps_pkg::ST_VICTIM:
            begin
                // Lowest free slot wins; otherwise the oldest timestamp, ties low.
                if (!used_reg[cnt_idx] && (used_reg[pick_reg] || cnt_idx < pick_reg))
                begin
                    pick_reg <= cnt_idx;
                    best_reg <= '0;
                end
                else if (used_reg[pick_reg] && used_reg[cnt_idx] && time_mem[cnt_idx] < best_reg)
                begin
                    pick_reg <= cnt_idx;
                    best_reg <= time_mem[cnt_idx];
                end
                if (cnt_last)
                    idx_reg <= (!used_reg[cnt_idx] && used_reg[pick_reg]) ? cnt_idx
                             : (used_reg[pick_reg] && used_reg[cnt_idx]
                                && time_mem[cnt_idx] < best_reg) ? cnt_idx : pick_reg;
            end
            aps_pkg::ST_DIV_START:
            begin
                e_reg     <= 25'd16777216;
                alpha_reg <= '0;
                comp_reg  <= 2'd0;
            end
            aps_pkg::ST_DIV_WAIT:
                if (div_done)
                begin
                    q_reg     <= div_q[15:0];
                    alpha_reg <= (div_q[32:16] != '0) ? 17'd65536 : 17'd0;
                end
            aps_pkg::ST_EXP:
            begin
                if (q_reg[cnt_reg[3:0]])
                    e_reg <= emul[48:24];
                if (state_next == aps_pkg::ST_BLEND_MUL && !alpha_reg[16])
                    alpha_reg <= 17'((25'd16777216 - (q_reg[cnt_reg[3:0]] ? emul[48:24] : e_reg)
                                      + 25'd128) >> 8);
            end
            aps_pkg::ST_BLEND_MUL:
                prod_reg <= bmul;
            aps_pkg::ST_BLEND_ADD:
            begin
                unique case (comp_reg)
                    2'd0:    ox_reg <= aps_pkg::sat32(blended);
                    2'd1:    oy_reg <= aps_pkg::sat32(blended);
                    default: oz_reg <= aps_pkg::sat32(blended);
                endcase
                comp_reg <= comp_reg + 2'd1;
            end
            aps_pkg::ST_WRITE:
            begin
                key_mem[idx_reg]  <= id_reg;
                offx_mem[idx_reg] <= ox_reg;
                offy_mem[idx_reg] <= oy_reg;
                offz_mem[idx_reg] <= oz_reg;
                time_mem[idx_reg] <= now_reg;
            end
            aps_pkg::ST_OUT:
                if (!out_valid_reg || out_ch.ready)
                begin
                    aim_x_reg  <= aps_pkg::sat32(34'(fx_reg) + (fb_reg ? 34'sd0 : 34'($signed(ox_reg))));
                    aim_y_reg  <= aps_pkg::sat32(34'(fy_reg) + (fb_reg ? 34'sd0 : 34'($signed(oy_reg))));
                    aim_z_reg  <= aps_pkg::sat32(34'(fz_reg) +
                        ((!fb_reg && $signed(oz_reg) < $signed(aps_pkg::MIN_ABOVE))
                         ? 34'(aps_pkg::MIN_ABOVE) : (fb_reg ? 34'(oz_reg) : 34'($signed(oz_reg)))));
                    out_fb_reg <= fb_reg;
                end
            default: ;
        endcase
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.aim_x         = aim_x_reg;
    assign out_ch.aim_y         = aim_y_reg;
    assign out_ch.aim_z         = aim_z_reg;
    assign out_ch.used_fallback = out_fb_reg;
endmodule

FILE: hw/rtl/aps_checker.sv
// Port-level checker for the aim point smoother, bound to the top level.
// Depends on aps_if through the top level's interface ports.
module aps_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [31:0] aim_x
);
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accepted a second word at once");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(aim_x)) else $error("result dropped");
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid || !in_ready) else $error("ready during work");
endmodule

bind aim_point_smoother aps_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .aim_x(out_ch.aim_x)
);

FILE: dv/tb_aim_point_smoother.sv
// Testbench for the aim point smoother: directed and random aim queries checked
// against a behavioral predictor of the slot table, weight and blend arithmetic.
// Depends on aps_pkg, aps_if and aim_point_smoother.
module tb_aim_point_smoother;

    typedef struct packed {
        logic [31:0] target_id;
        logic [47:0] time_us;
        logic        bound_valid;
        logic [31:0] centre_x;
        logic [31:0] centre_y;
        logic [31:0] centre_z;
        logic [30:0] sphere_radius;
        logic [31:0] feet_x;
        logic [31:0] feet_y;
        logic [31:0] feet_z;
    } query_t;

    typedef struct packed {
        logic [31:0] aim_x;
        logic [31:0] aim_y;
        logic [31:0] aim_z;
        logic        used_fallback;
    } aim_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    aps_in_if  in_ch();
    aps_out_if out_ch();

    aim_point_smoother u_dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor copy of the configuration and slot table.
    logic [19:0] fallback_h;
    logic [11:0] factor;
    logic [23:0] tau_us;
    logic        used [aps_pkg::SLOTS];
    logic [31:0] keys [aps_pkg::SLOTS];
    longint      offx [aps_pkg::SLOTS];
    longint      offy [aps_pkg::SLOTS];
    longint      offz [aps_pkg::SLOTS];
    logic [47:0] last_t [aps_pkg::SLOTS];

    query_t pending_q[$];
    aim_t   expected_aims[$];
    int     errors = 0;
    int     hold_off = 0;
    int     recv_gap = 0;
    logic   in_flight;

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_div16(longint v);
        if (v >= 0) return v / 65536;
        return -((-v + 65535) / 65536);
    endfunction

    function automatic longint alpha_for(logic [63:0] dt);
        logic [63:0] q;
        logic [63:0] e;
        logic [23:0] f;
        q = (dt << 12) / tau_us;
        e = 64'd1 << 24;
        if (q >= 65536) return 65536;
        for (int k = 0; k < 16; k++)
        begin
            f = aps_pkg::exp_factor(k[3:0]);
            if (q[k]) e = (e * f + (64'd1 << 23)) >> 24;
        end
        return longint'(((64'd1 << 24) - e + 128) >> 8);
    endfunction

    function automatic longint blend(longint old, longint raw, longint a);
        return clamp32(old + floor_div16((raw - old) * a + 32768));
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < aps_pkg::SLOTS; i++)
        begin
            used[i] = 0; keys[i] = 0; offx[i] = 0; offy[i] = 0; offz[i] = 0;
            last_t[i] = 0;
        end
    endfunction

    function automatic aim_t predict_aim(query_t q);
        aim_t r;
        longint fx, fy, fz, ox, oy, oz, above, h, a, floor_z;
        int hit, pick;
        logic [47:0] prev;
        floor_z = longint'(aps_pkg::MIN_ABOVE);
        fx = longint'(signed'(q.feet_x));
        fy = longint'(signed'(q.feet_y));
        fz = longint'(signed'(q.feet_z));
        if (!q.bound_valid || q.sphere_radius < aps_pkg::RADIUS_MIN
            || q.sphere_radius > aps_pkg::RADIUS_MAX)
        begin
            r.aim_x = fx[31:0];
            r.aim_y = fy[31:0];
            r.aim_z = 32'(clamp32(fz + longint'(fallback_h)));
            r.used_fallback = 1;
            return r;
        end
        above = longint'(signed'(q.centre_z)) - fz;
        if (above < 0) above = 0;
        h = (above * longint'(factor)) / 256;
        if (h < floor_z) h = floor_z;
        ox = clamp32(longint'(signed'(q.centre_x)) - fx);
        oy = clamp32(longint'(signed'(q.centre_y)) - fy);
        oz = clamp32(h);
        if (tau_us != 0)
        begin
            hit = -1;
            pick = -1;
            for (int i = 0; i < aps_pkg::SLOTS; i++)
                if (hit < 0 && used[i] && keys[i] == q.target_id) hit = i;
            if (hit < 0)
            begin
                for (int i = 0; i < aps_pkg::SLOTS; i++)
                    if (pick < 0 && !used[i]) pick = i;
                if (pick < 0)
                begin
                    pick = 0;
                    for (int i = 1; i < aps_pkg::SLOTS; i++)
                        if (last_t[i] < last_t[pick]) pick = i;
                end
                used[pick] = 1; keys[pick] = q.target_id;
                offx[pick] = ox; offy[pick] = oy; offz[pick] = oz;
                last_t[pick] = q.time_us;
            end
            else
            begin
                prev = last_t[hit];
                last_t[hit] = q.time_us;
                if (q.time_us <= prev || q.time_us - prev > aps_pkg::STALE_US)
                begin
                    offx[hit] = ox; offy[hit] = oy; offz[hit] = oz;
                end
                else
                begin
                    a = alpha_for(64'(q.time_us - prev));
                    offx[hit] = blend(offx[hit], ox, a);
                    offy[hit] = blend(offy[hit], oy, a);
                    offz[hit] = blend(offz[hit], oz, a);
                    ox = offx[hit]; oy = offy[hit]; oz = offz[hit];
                end
            end
        end
        if (oz < floor_z) oz = floor_z;
        r.aim_x = 32'(clamp32(fx + ox));
        r.aim_y = 32'(clamp32(fy + oy));
        r.aim_z = 32'(clamp32(fz + oz));
        r.used_fallback = 0;
        return r;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sender: offers the head of the queue, with random gaps between words.
    int send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 0;
            in_flight = 0;
        end
        else
        begin
            if (in_flight && in_ch.ready)
            begin
                expected_aims.push_back(predict_aim(pending_q.pop_front()));
                in_flight = 0;
                send_gap = gap_len();
            end
            if (!in_flight && pending_q.size() > 0 && send_gap == 0)
            begin
                {in_ch.target_id, in_ch.time_us, in_ch.bound_valid, in_ch.centre_x,
                 in_ch.centre_y, in_ch.centre_z, in_ch.sphere_radius, in_ch.feet_x,
                 in_ch.feet_y, in_ch.feet_z} <= pending_q[0];
                in_flight = 1;
            end
            else if (send_gap > 0)
                send_gap--;
            in_ch.valid <= in_flight;
        end
    end

    // Receiver: checks each accepted word and idles for random stretches.
    always @(posedge clk or negedge rst_n)
    begin
        aim_t got, exp_aim;
        if (!rst_n)
            out_ch.ready <= 0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = {out_ch.aim_x, out_ch.aim_y, out_ch.aim_z, out_ch.used_fallback};
                if (expected_aims.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, actual %h", $time, got);
                end
                else
                begin
                    exp_aim = expected_aims.pop_front();
                    if (got !== exp_aim)
                    begin
                        errors++;
                        $display("%0t: mismatch expected x=%h y=%h z=%h fb=%b actual x=%h y=%h z=%h fb=%b",
                                 $time, exp_aim.aim_x, exp_aim.aim_y, exp_aim.aim_z,
                                 exp_aim.used_fallback, got.aim_x, got.aim_y, got.aim_z,
                                 got.used_fallback);
                    end
                end
                recv_gap = gap_len();
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ch.ready <= 0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ch.ready <= 0;
            end
            else
                out_ch.ready <= 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        case (idx)
            aps_pkg::REG_FALLBACK: fallback_h = val[19:0];
            aps_pkg::REG_FACTOR:   factor = val[11:0];
            default:               tau_us = val;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || in_flight || expected_aims.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    function automatic query_t random_query(int n_ids, logic [47:0] t);
        query_t q;
        int p;
        q.target_id = (n_ids > 0) ? 32'($urandom_range(1, n_ids)) * 32'h9E3779B1 : $urandom;
        q.time_us = t;
        q.bound_valid = ($urandom_range(0, 9) != 0);
        p = $urandom_range(0, 9);
        q.sphere_radius = (p == 0) ? 31'($urandom) : (p == 1) ? 31'($urandom_range(3270, 3285))
                        : (p == 2) ? 31'($urandom_range(655350, 655370))
                        : 31'($urandom_range(3277, 655359));
        q.feet_x = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 24)) - (1 << 23);
        q.feet_y = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 24)) - (1 << 23);
        q.feet_z = $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 1 << 24)) - (1 << 23);
        q.centre_x = $urandom_range(0, 3) == 0 ? $urandom : q.feet_x + 32'($urandom_range(0, 1 << 18)) - (1 << 17);
        q.centre_y = $urandom_range(0, 3) == 0 ? $urandom : q.feet_y + 32'($urandom_range(0, 1 << 18)) - (1 << 17);
        q.centre_z = $urandom_range(0, 3) == 0 ? $urandom : q.feet_z + 32'($urandom_range(0, 1 << 19)) - (1 << 16);
        return q;
    endfunction

    initial
    begin
        query_t q;
        logic [47:0] t;
        rst_n = 0;
        cfg_we = 0; cfg_index = aps_pkg::REG_FALLBACK; cfg_data = 0;
        in_ch.valid = 0;
        in_ch.target_id = 0; in_ch.time_us = 0; in_ch.bound_valid = 0;
        in_ch.centre_x = 0; in_ch.centre_y = 0; in_ch.centre_z = 0;
        in_ch.sphere_radius = 0; in_ch.feet_x = 0; in_ch.feet_y = 0; in_ch.feet_z = 0;
        out_ch.ready = 0;
        fallback_h = aps_pkg::FALLBACK_RST; factor = aps_pkg::FACTOR_RST;
        tau_us = aps_pkg::SMOOTH_RST;
        clear_table();
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: fallback paths, radius band edges, extreme coordinates.
        q = '0; q.target_id = 32'hFFFF_FFFF; q.feet_z = 32'h7FFF_FFF0;
        pending_q.push_back(q);
        q.bound_valid = 1; q.sphere_radius = 31'd3276; pending_q.push_back(q);
        q.sphere_radius = 31'd655360; pending_q.push_back(q);
        q.sphere_radius = 31'h7FFF_FFFF; q.feet_z = 32'h8000_0000; pending_q.push_back(q);
        // Usable bounds: band edges, saturating offsets, height floor.
        q.sphere_radius = 31'd3277; q.feet_x = 32'h8000_0000; q.centre_x = 32'h7FFF_FFFF;
        q.feet_y = 32'h7FFF_FFFF; q.centre_y = 32'h8000_0000;
        q.feet_z = 32'h8000_0000; q.centre_z = 32'h7FFF_FFFF; q.time_us = 48'd100;
        pending_q.push_back(q);
        q.sphere_radius = 31'd655359; q.centre_z = 32'h8000_0000; q.feet_z = 32'd0;
        q.time_us = 48'd200; pending_q.push_back(q);
        // Same key: a normal blend, a stale gap, a backward time, the max timestamp.
        q.centre_x = 32'h0001_0000; q.feet_x = 32'd0; q.centre_y = 32'd0; q.feet_y = 32'd0;
        q.centre_z = 32'h0002_0000;
        q.time_us = 48'd50200; pending_q.push_back(q);
        q.time_us = 48'd50200 + 48'd1500001; pending_q.push_back(q);
        q.time_us = 48'd1000; pending_q.push_back(q);
        q.time_us = 48'hFFFF_FFFF_FFFF; pending_q.push_back(q);
        // Ten distinct keys force least-recently-used replacement.
        for (int i = 1; i <= 10; i++)
        begin
            q.target_id = 32'(i); q.time_us = 48'(i * 1000); pending_q.push_back(q);
        end
        drain();

        // Random phases through several register settings, extremes included.
        t = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(aps_pkg::REG_FALLBACK, 24'd0);
                         write_reg(aps_pkg::REG_FACTOR, 24'd0);
                         write_reg(aps_pkg::REG_SMOOTH, 24'd0); end
                1: begin write_reg(aps_pkg::REG_FALLBACK, 24'hFFFFF);
                         write_reg(aps_pkg::REG_FACTOR, 24'hFFF);
                         write_reg(aps_pkg::REG_SMOOTH, 24'd1); end
                2: begin write_reg(aps_pkg::REG_FALLBACK, 24'd524288);
                         write_reg(aps_pkg::REG_FACTOR, 24'd2048);
                         write_reg(aps_pkg::REG_SMOOTH, 24'hFFFFFF); end
                3: begin write_reg(aps_pkg::REG_FALLBACK, 24'(aps_pkg::FALLBACK_RST));
                         write_reg(aps_pkg::REG_FACTOR, 24'(aps_pkg::FACTOR_RST));
                         write_reg(aps_pkg::REG_SMOOTH, aps_pkg::SMOOTH_RST); end
                4: begin write_reg(aps_pkg::REG_FACTOR, 24'($urandom_range(0, 4095)));
                         write_reg(aps_pkg::REG_SMOOTH, 24'($urandom_range(1000, 400000))); end
                default: write_reg(aps_pkg::REG_SMOOTH, 24'd10000000);
            endcase
            for (int n = 0; n < 170; n++)
            begin
                t = t + ($urandom_range(0, 19) == 0 ? 48'($urandom_range(0, 3000000))
                                                   : 48'($urandom_range(0, 60000)));
                q = random_query($urandom_range(0, 7) == 0 ? 0 : 12, t);
                if ($urandom_range(0, 29) == 0) q.time_us = 48'({$urandom, $urandom});
                pending_q.push_back(q);
                if (ph == 3 && n == 20)
                    hold_off = 400;
            end
            drain();
        end

        if (errors == 0)
            $display("** aim_point_smoother: PASSED **");
        else
            $display("** aim_point_smoother: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("** aim_point_smoother: FAILED **");
        $finish;
    end
endmodule
